// ===== rtl/ddsa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ddsa_pkg: shared types and constants for the decimal digit string adder
// Holds the digit-store size, the transaction payload types, the status codes
// and the command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package ddsa_pkg;

    localparam int MAX_DIGITS = 32;
    localparam int CNT_W      = $clog2(MAX_DIGITS);
    localparam int DIGIT_W    = 4;
    localparam int LEN_W      = 6;
    localparam int STAT_W     = 2;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_INVALID  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit_a;
        logic [DIGIT_W-1:0] digit_b;
        logic               operand_invalid;
        logic               last_position;
    } in_item_t;

    typedef struct packed {
        logic [DIGIT_W-1:0] sum_digit;
        logic [LEN_W-1:0]   sum_length;
        logic [STAT_W-1:0]  status;
        logic               last_digit;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic take_item;   // input transaction completes this cycle
        logic drain_step;  // load the next result digit into the output register
        logic out_pop;     // output transaction completes this cycle
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_valid;   // output register holds a result
        logic item_last;   // current input item closes the run
        logic item_fail;   // run closing now ends in a single error result
        logic drain_final; // next drain step delivers the least significant digit
    } dp_sts_t;

endpackage
`default_nettype wire

// ===== rtl/decimal_digit_string_adder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_digit_string_adder: adds two decimal digit strings
// Takes one digit position per transaction, least significant first, and
// returns the sum digits most significant first, or a single error result.
// ----------------------------------------------------------------------------
// Each input transaction carries the digits of both operands at one position
// (shorter operand padded with zero); the transaction flagged last_position
// closes the run. While loading, one position is taken per cycle, provided the
// output register is empty or being emptied. After the last position the block
// drains its digit file, one result per cycle while m_ready is high; the next
// run's first position is taken only after the least significant digit has
// entered the output register. An invalid operand or a digit above nine gives
// one result with status invalid; a sum needing MAX_DIGITS or more digits
// gives one result with status overflow; in both cases the block stays in its
// load state, ready for the next run. A final carry is emitted as a leading
// digit 1 without a write to the digit file.
// ----------------------------------------------------------------------------
module decimal_digit_string_adder
    import ddsa_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    // Digit position channel
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_item,
    // Result digit channel
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_item
);

    ctl_cmd_t cmd;
    dp_sts_t  sts;

    // Sequencer: hold the input off while draining, advance the drain pointer
    ddsa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Datapath: decimal add, digit file, output register
    ddsa_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .cmd     (cmd),
        .sts     (sts),
        .m_item  (m_item)
    );

    // Result valid comes straight from the output register
    assign m_valid = sts.out_valid;

endmodule
`default_nettype wire

// ===== rtl/ddsa_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ddsa_ctrl: load / drain sequencer
// Owns the input handshake and decides when the datapath takes a digit
// position and when it moves a stored digit into the output register.
// ----------------------------------------------------------------------------
module ddsa_ctrl
    import ddsa_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire logic     m_ready,
    input  wire dp_sts_t  sts,
    output ctl_cmd_t      cmd
);

    localparam logic S_LOAD  = 1'b0;
    localparam logic S_DRAIN = 1'b1;

    logic state_reg;
    logic state_next;
    logic slot_free;

    // Output register is free, or empties in this same cycle
    assign slot_free = !sts.out_valid || m_ready;

    always_comb begin
        s_ready        = (state_reg == S_LOAD) && slot_free;
        cmd.take_item  = s_valid && s_ready;
        cmd.drain_step = (state_reg == S_DRAIN) && slot_free;
        cmd.out_pop    = sts.out_valid && m_ready;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD: begin
                if (cmd.take_item && sts.item_last && !sts.item_fail) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (cmd.drain_step && sts.drain_final) begin
                    state_next = S_LOAD;
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ddsa_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ddsa_datapath: decimal add, digit file and output register
// Adds one digit position per command with a decimal carry, stores the sum
// digits and feeds them back most significant first into the output register.
// ----------------------------------------------------------------------------
module ddsa_datapath
    import ddsa_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire in_item_t  s_item,
    input  wire ctl_cmd_t  cmd,
    output dp_sts_t        sts,
    output out_item_t      m_item
);

    logic [DIGIT_W-1:0] digit_file [MAX_DIGITS];
    logic [DIGIT_W-1:0] rd_digit_reg;

    logic               carry_reg,    carry_next;
    logic [CNT_W-1:0]   count_reg,    count_next;
    logic               invalid_reg,  invalid_next;
    logic               overflow_reg, overflow_next;
    logic               drain_hi_reg, drain_hi_next;
    logic [CNT_W-1:0]   rd_ptr_reg,   rd_ptr_next;
    logic [LEN_W-1:0]   len_reg,      len_next;
    logic               m_valid_reg,  m_valid_next;
    out_item_t          m_item_reg,   m_item_next;

    logic               invalid_now;
    logic               overflow_now;
    logic               active;
    logic [DIGIT_W:0]   sum_raw;
    logic               carry_out;
    logic [DIGIT_W-1:0] sum_dig;
    logic               cnt_full;
    logic               push_ok;
    logic [CNT_W-1:0]   cnt_after;
    logic               hi_digit;
    logic               hi_ovf;
    logic               fail_last;
    logic [LEN_W-1:0]   len_final;
    logic               wr_en;
    logic               finish;
    logic               load_out;

    always_comb begin
        invalid_now = invalid_reg || s_item.operand_invalid
                      || (s_item.digit_a > 4'd9) || (s_item.digit_b > 4'd9);
        active      = !invalid_now && !overflow_reg;
        sum_raw     = {1'b0, s_item.digit_a} + {1'b0, s_item.digit_b}
                      + {{DIGIT_W{1'b0}}, carry_reg};
        carry_out   = sum_raw > 5'd9;
        sum_dig     = carry_out ? DIGIT_W'(sum_raw - 5'd10) : sum_raw[DIGIT_W-1:0];
        cnt_full    = count_reg == CNT_W'(MAX_DIGITS - 1);
        push_ok     = active && !cnt_full;
        overflow_now = overflow_reg || (active && cnt_full);
        cnt_after   = push_ok ? count_reg + CNT_W'(1) : count_reg;
        // Final carry becomes a leading digit 1, emitted from a flag
        hi_digit    = push_ok && carry_out;
        hi_ovf      = hi_digit && (cnt_after == CNT_W'(MAX_DIGITS - 1));
        fail_last   = invalid_now || overflow_now || hi_ovf;
        len_final   = LEN_W'(cnt_after) + LEN_W'(hi_digit);
        wr_en       = cmd.take_item && push_ok;
        finish      = cmd.take_item && s_item.last_position;
        load_out    = (finish && fail_last) || cmd.drain_step;
    end

    always_comb begin
        carry_next    = carry_reg;
        count_next    = count_reg;
        invalid_next  = invalid_reg;
        overflow_next = overflow_reg;
        drain_hi_next = drain_hi_reg;
        rd_ptr_next   = rd_ptr_reg;
        len_next      = len_reg;
        m_item_next   = m_item_reg;

        if (cmd.take_item) begin
            carry_next    = push_ok ? carry_out : carry_reg;
            count_next    = cnt_after;
            invalid_next  = invalid_now;
            overflow_next = overflow_now;
        end

        if (finish) begin
            carry_next    = 1'b0;
            count_next    = '0;
            invalid_next  = 1'b0;
            overflow_next = 1'b0;
            if (fail_last) begin
                m_item_next.sum_digit  = '0;
                m_item_next.sum_length = '0;
                m_item_next.status     = invalid_now ? STAT_INVALID : STAT_OVERFLOW;
                m_item_next.last_digit = 1'b1;
            end else begin
                drain_hi_next = hi_digit;
                rd_ptr_next   = cnt_after - CNT_W'(1);
                len_next      = len_final;
            end
        end

        if (cmd.drain_step) begin
            m_item_next.sum_length = len_reg;
            m_item_next.status     = STAT_OK;
            if (drain_hi_reg) begin
                m_item_next.sum_digit  = DIGIT_W'(1);
                m_item_next.last_digit = 1'b0;
                drain_hi_next          = 1'b0;
            end else begin
                m_item_next.sum_digit  = rd_digit_reg;
                m_item_next.last_digit = rd_ptr_reg == '0;
                rd_ptr_next            = rd_ptr_reg - CNT_W'(1);
            end
        end

        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (cmd.out_pop) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Fetch the digit for the next drain step; pass a digit written at the
    // same edge straight through
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            digit_file[count_reg] <= sum_dig;
        end
        if (wr_en && (count_reg == rd_ptr_next)) begin
            rd_digit_reg <= sum_dig;
        end else begin
            rd_digit_reg <= digit_file[rd_ptr_next];
        end
    end

    always_ff @(posedge aclk) begin
        rd_ptr_reg <= rd_ptr_next;
        len_reg    <= len_next;
        m_item_reg <= m_item_next;
        if (!aresetn) begin
            carry_reg    <= 1'b0;
            count_reg    <= '0;
            invalid_reg  <= 1'b0;
            overflow_reg <= 1'b0;
            drain_hi_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            carry_reg    <= carry_next;
            count_reg    <= count_next;
            invalid_reg  <= invalid_next;
            overflow_reg <= overflow_next;
            drain_hi_reg <= drain_hi_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_comb begin
        sts.out_valid   = m_valid_reg;
        sts.item_last   = s_item.last_position;
        sts.item_fail   = fail_last;
        sts.drain_final = !drain_hi_reg && (rd_ptr_reg == '0);
    end

    assign m_item = m_item_reg;

    // A pending result is never overwritten before it is taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out && m_valid_reg |-> cmd.out_pop)
        else $error("result overwritten in output register");

    // Error results carry no digits and close the run
    a_error_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_item_reg.status != STAT_OK) |->
            (m_item_reg.sum_length == '0) && m_item_reg.last_digit
            && (m_item_reg.sum_digit == '0))
        else $error("malformed error result");

    // Run state is clean once a run has closed
    a_run_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        finish |=> (count_reg == '0) && !carry_reg && !invalid_reg && !overflow_reg)
        else $error("run state not cleared after last position");

endmodule
`default_nettype wire
